@@ sv/tgrr_pkg.sv @@
// Shared types, codes and constants for the three-group round-robin scheduler.
// Used by tgrr_engine and the top level; depends on nothing else.
package tgrr_pkg;

  localparam int PLAYER_SLOTS_DEF = 5;
  localparam int FIXED_SLOTS_DEF  = 15;

  localparam int BASE_W  = 13;
  localparam int POS_W   = 8;
  localparam int SEL_W   = 16;
  localparam int SLOT_W  = 4;
  localparam int GROUP_W = 2;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [BASE_W-1:0] BASE_FIXED_RST = 13'd11;
  localparam logic [BASE_W-1:0] BASE_A_RST     = 13'd26;
  localparam logic [BASE_W-1:0] BASE_B_RST     = 13'd31;

  localparam logic [MODE_W-1:0] MODE_ADD_A  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD_B  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SELECT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_KILL   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd2;

  localparam logic [GROUP_W-1:0] GRP_A     = 2'd0;
  localparam logic [GROUP_W-1:0] GRP_B     = 2'd1;
  localparam logic [GROUP_W-1:0] GRP_FIXED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_FIXED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_A     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_B     = 2'd2;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SEL_W-1:0]   selector;
    logic [GROUP_W-1:0] group;
    logic [SLOT_W-1:0]  slot;
    logic [POS_W-1:0]   task_x;
    logic [POS_W-1:0]   task_y;
  } result_t;

  typedef struct packed {
    logic [BASE_W-1:0] fixed;
    logic [BASE_W-1:0] a;
    logic [BASE_W-1:0] b;
  } bases_t;

  // Turn order is A, B, fixed, then back to A.
  function automatic logic [GROUP_W-1:0] next_group(input logic [GROUP_W-1:0] g);
    logic [GROUP_W-1:0] r;
    case (g)
      GRP_A:   r = GRP_B;
      GRP_B:   r = GRP_FIXED;
      default: r = GRP_A;
    endcase
    return r;
  endfunction

  // Built-in coordinates of the fixed group; slots past the table sit at the origin.
  function automatic logic [2*POS_W-1:0] fixed_pos(input logic [4:0] idx);
    logic [2*POS_W-1:0] p;  // {row, column}
    case (idx)
      5'd0:    p = {8'd2,  8'd10};
      5'd1:    p = {8'd3,  8'd55};
      5'd2:    p = {8'd6,  8'd29};
      5'd3:    p = {8'd9,  8'd71};
      5'd4:    p = {8'd13, 8'd39};
      5'd5:    p = {8'd16, 8'd3};
      5'd6:    p = {8'd17, 8'd52};
      5'd7:    p = {8'd19, 8'd70};
      5'd8:    p = {8'd22, 8'd37};
      5'd9:    p = {8'd26, 8'd18};
      5'd10:   p = {8'd31, 8'd7};
      5'd11:   p = {8'd30, 8'd56};
      5'd12:   p = {8'd34, 8'd33};
      5'd13:   p = {8'd35, 8'd74};
      5'd14:   p = {8'd42, 8'd47};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

@@ sv/tgrr_pick.sv @@
// Rotating priority encoder: finds the first alive slot after a cursor, with wraparound.
// Standalone; instantiated once per slot group by tgrr_engine.
module tgrr_pick #(
  parameter int N  = 5,
  parameter int IW = 3
) (
  input  logic [N-1:0]  alive,
  input  logic [IW-1:0] cursor,
  output logic          found,
  output logic [IW-1:0] idx
);

  logic [N-1:0]  above;
  logic          hi_found;
  logic [IW-1:0] hi_idx;
  logic [IW-1:0] lo_idx;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      above[i] = alive[i] && (IW'(i) > cursor);
    end
  end

  // Scanning downward leaves the lowest set position in the index.
  always_comb begin
    hi_idx = '0;
    lo_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (above[i]) begin
        hi_idx = IW'(i);
      end
      if (alive[i]) begin
        lo_idx = IW'(i);
      end
    end
  end

  assign hi_found = |above;
  assign found    = |alive;
  assign idx      = hi_found ? hi_idx : lo_idx;

endmodule

@@ sv/tgrr_engine.sv @@
// Scheduler state (alive masks, cursors, turn, stored positions) and the
// step logic for add, select-next and kill. Depends on tgrr_pkg and tgrr_pick.
module tgrr_engine #(
  parameter int PLAYER_SLOTS = tgrr_pkg::PLAYER_SLOTS_DEF,
  parameter int FIXED_SLOTS  = tgrr_pkg::FIXED_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  logic [tgrr_pkg::MODE_W-1:0] mode,
  input  logic [tgrr_pkg::POS_W-1:0]  pos_x,
  input  logic [tgrr_pkg::POS_W-1:0]  pos_y,
  input  tgrr_pkg::bases_t            bases,
  output tgrr_pkg::result_t           res
);
  import tgrr_pkg::*;

  localparam int PIW = (PLAYER_SLOTS > 1) ? $clog2(PLAYER_SLOTS) : 1;
  localparam int FIW = (FIXED_SLOTS > 1) ? $clog2(FIXED_SLOTS) : 1;
  localparam int SW  = (PIW > FIW) ? PIW : FIW;

  logic [GROUP_W-1:0]      turn_group;
  logic [PIW-1:0]          cursor_a;
  logic [PIW-1:0]          cursor_b;
  logic [FIW-1:0]          cursor_fixed;
  logic [PLAYER_SLOTS-1:0] alive_a;
  logic [PLAYER_SLOTS-1:0] alive_b;
  logic [FIXED_SLOTS-1:0]  alive_fixed;
  logic [POS_W-1:0]        pos_a_x [PLAYER_SLOTS];
  logic [POS_W-1:0]        pos_a_y [PLAYER_SLOTS];
  logic [POS_W-1:0]        pos_b_x [PLAYER_SLOTS];
  logic [POS_W-1:0]        pos_b_y [PLAYER_SLOTS];

  logic           found_a, found_b, found_f;
  logic [PIW-1:0] pick_a, pick_b;
  logic [FIW-1:0] pick_f;

  tgrr_pick #(.N(PLAYER_SLOTS), .IW(PIW)) u_pick_a (
    .alive(alive_a), .cursor(cursor_a), .found(found_a), .idx(pick_a)
  );
  tgrr_pick #(.N(PLAYER_SLOTS), .IW(PIW)) u_pick_b (
    .alive(alive_b), .cursor(cursor_b), .found(found_b), .idx(pick_b)
  );
  tgrr_pick #(.N(FIXED_SLOTS), .IW(FIW)) u_pick_f (
    .alive(alive_fixed), .cursor(cursor_fixed), .found(found_f), .idx(pick_f)
  );

  // Lowest free slot of each player group, for add.
  logic [PIW-1:0] free_a, free_b;
  logic           full_a, full_b;

  always_comb begin
    free_a = '0;
    free_b = '0;
    for (int i = PLAYER_SLOTS - 1; i >= 0; i--) begin
      if (!alive_a[i]) begin
        free_a = PIW'(i);
      end
      if (!alive_b[i]) begin
        free_b = PIW'(i);
      end
    end
  end

  assign full_a = &alive_a;
  assign full_b = &alive_b;

  // Select-next group: first with an alive slot after the turn, turn group last.
  logic [GROUP_W-1:0] sel_group;
  logic               sel_any;

  always_comb begin
    logic [GROUP_W-1:0] g;
    logic               has;
    g         = turn_group;
    sel_group = GRP_A;
    sel_any   = 1'b0;
    for (int k = 0; k < 3; k++) begin
      g = next_group(g);
      case (g)
        GRP_A:   has = found_a;
        GRP_B:   has = found_b;
        default: has = found_f;
      endcase
      if (!sel_any && has) begin
        sel_any   = 1'b1;
        sel_group = g;
      end
    end
  end

  // One read address per player position array.
  logic [PIW-1:0]     rd_a, rd_b;
  logic [2*POS_W-1:0] fpos_pick, fpos_cur;

  assign rd_a      = (mode == MODE_KILL) ? cursor_a : pick_a;
  assign rd_b      = (mode == MODE_KILL) ? cursor_b : pick_b;
  assign fpos_pick = fixed_pos(5'(pick_f));
  assign fpos_cur  = fixed_pos(5'(cursor_fixed));

  // Result of the current request.
  logic               hit;
  logic [GROUP_W-1:0] g_out;
  logic [SW-1:0]      s_out;
  logic [POS_W-1:0]   x_out, y_out;
  logic [STAT_W-1:0]  st_out;
  logic [BASE_W-1:0]  base_out;
  logic               kill_alive;

  always_comb begin
    st_out     = ST_OK;
    hit        = 1'b0;
    g_out      = GRP_A;
    s_out      = '0;
    x_out      = '0;
    y_out      = '0;
    kill_alive = 1'b0;
    case (mode)
      MODE_ADD_A: begin
        g_out = GRP_A;
        if (full_a) begin
          st_out = ST_FULL;
        end else begin
          hit   = 1'b1;
          s_out = SW'(free_a);
          x_out = pos_x;
          y_out = pos_y;
        end
      end
      MODE_ADD_B: begin
        g_out = GRP_B;
        if (full_b) begin
          st_out = ST_FULL;
        end else begin
          hit   = 1'b1;
          s_out = SW'(free_b);
          x_out = pos_x;
          y_out = pos_y;
        end
      end
      MODE_SELECT: begin
        if (!sel_any) begin
          st_out = ST_NONE;
        end else begin
          hit   = 1'b1;
          g_out = sel_group;
          case (sel_group)
            GRP_A: begin
              s_out = SW'(pick_a);
              x_out = pos_a_x[rd_a];
              y_out = pos_a_y[rd_a];
            end
            GRP_B: begin
              s_out = SW'(pick_b);
              x_out = pos_b_x[rd_b];
              y_out = pos_b_y[rd_b];
            end
            default: begin
              s_out = SW'(pick_f);
              x_out = fpos_pick[POS_W-1:0];
              y_out = fpos_pick[2*POS_W-1:POS_W];
            end
          endcase
        end
      end
      default: begin
        // Kill acts on the cursor slot of the group holding the turn.
        g_out = turn_group;
        case (turn_group)
          GRP_A: begin
            s_out      = SW'(cursor_a);
            kill_alive = alive_a[cursor_a];
            x_out      = pos_a_x[rd_a];
            y_out      = pos_a_y[rd_a];
          end
          GRP_B: begin
            s_out      = SW'(cursor_b);
            kill_alive = alive_b[cursor_b];
            x_out      = pos_b_x[rd_b];
            y_out      = pos_b_y[rd_b];
          end
          default: begin
            s_out      = SW'(cursor_fixed);
            kill_alive = alive_fixed[cursor_fixed];
            x_out      = fpos_cur[POS_W-1:0];
            y_out      = fpos_cur[2*POS_W-1:POS_W];
          end
        endcase
        hit    = kill_alive;
        st_out = kill_alive ? ST_OK : ST_NONE;
      end
    endcase
  end

  always_comb begin
    case (g_out)
      GRP_A:   base_out = bases.a;
      GRP_B:   base_out = bases.b;
      default: base_out = bases.fixed;
    endcase
  end

  always_comb begin
    res.status   = st_out;
    res.selector = hit ? {base_out + BASE_W'(s_out), 3'b000} : '0;
    res.group    = g_out;
    res.slot     = SLOT_W'(s_out);
    res.task_x   = x_out;
    res.task_y   = y_out;
  end

  // State update, taken when the request moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_group   <= GRP_FIXED;
      cursor_a     <= '0;
      cursor_b     <= '0;
      cursor_fixed <= '0;
      alive_a      <= '0;
      alive_b      <= '0;
      alive_fixed  <= '1;
      for (int i = 0; i < PLAYER_SLOTS; i++) begin
        pos_a_x[i] <= '0;
        pos_a_y[i] <= '0;
        pos_b_x[i] <= '0;
        pos_b_y[i] <= '0;
      end
    end else if (fire) begin
      case (mode)
        MODE_ADD_A: begin
          if (!full_a) begin
            alive_a[free_a] <= 1'b1;
            pos_a_x[free_a] <= pos_x;
            pos_a_y[free_a] <= pos_y;
          end
        end
        MODE_ADD_B: begin
          if (!full_b) begin
            alive_b[free_b] <= 1'b1;
            pos_b_x[free_b] <= pos_x;
            pos_b_y[free_b] <= pos_y;
          end
        end
        MODE_SELECT: begin
          if (sel_any) begin
            turn_group <= sel_group;
            case (sel_group)
              GRP_A:   cursor_a     <= pick_a;
              GRP_B:   cursor_b     <= pick_b;
              default: cursor_fixed <= pick_f;
            endcase
          end
        end
        default: begin
          case (turn_group)
            GRP_A:   alive_a[cursor_a]         <= 1'b0;
            GRP_B:   alive_b[cursor_b]         <= 1'b0;
            default: alive_fixed[cursor_fixed] <= 1'b0;
          endcase
        end
      endcase
    end
  end

endmodule

@@ sv/three_group_round_robin_task_scheduler.sv @@
// Three-group round-robin task scheduler: accepts one request per clock unless in_stall is
// raised. A request passes the input register, then the result register, where out_valid
// rises with its result; out_stall can hold it in the input register between the two.
// The whole add, select-next or kill step is one pass of priority encoders between the
// two registers, so the rate is one request per cycle whenever the output is not stalled.
// Depends on tgrr_pkg and tgrr_engine.
module three_group_round_robin_task_scheduler #(
  parameter int PLAYER_SLOTS = tgrr_pkg::PLAYER_SLOTS_DEF,
  parameter int FIXED_SLOTS  = tgrr_pkg::FIXED_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tgrr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tgrr_pkg::BASE_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tgrr_pkg::MODE_W-1:0]    mode,
  input  logic [tgrr_pkg::POS_W-1:0]     pos_x,
  input  logic [tgrr_pkg::POS_W-1:0]     pos_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tgrr_pkg::STAT_W-1:0]    status,
  output logic [tgrr_pkg::SEL_W-1:0]     selector,
  output logic [tgrr_pkg::GROUP_W-1:0]   group,
  output logic [tgrr_pkg::SLOT_W-1:0]    slot,
  output logic [tgrr_pkg::POS_W-1:0]     task_x,
  output logic [tgrr_pkg::POS_W-1:0]     task_y
);
  import tgrr_pkg::*;

  bases_t            bases;
  logic              in_full;
  logic [MODE_W-1:0] mode_r;
  logic [POS_W-1:0]  x_r, y_r;
  logic              out_full;
  result_t           res;
  result_t           res_r;
  logic              advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      bases.fixed <= BASE_FIXED_RST;
      bases.a     <= BASE_A_RST;
      bases.b     <= BASE_B_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_FIXED: bases.fixed <= cfg_data;
        REG_BASE_A:     bases.a     <= cfg_data;
        REG_BASE_B:     bases.b     <= cfg_data;
        default: ;
      endcase
    end
  end

  // A held request moves on when the result register is empty or being drained.
  assign advance  = in_full && (!out_full || !out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      mode_r <= mode;
      x_r    <= pos_x;
      y_r    <= pos_y;
    end
  end

  tgrr_engine #(.PLAYER_SLOTS(PLAYER_SLOTS), .FIXED_SLOTS(FIXED_SLOTS)) u_engine (
    .clk   (clk),
    .rst   (rst),
    .fire  (advance),
    .mode  (mode_r),
    .pos_x (x_r),
    .pos_y (y_r),
    .bases (bases),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (!out_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid = out_full;
  assign status    = res_r.status;
  assign selector  = res_r.selector;
  assign group     = res_r.group;
  assign slot      = res_r.slot;
  assign task_x    = res_r.task_x;
  assign task_y    = res_r.task_y;

endmodule
